// ===== sv/rrss_pkg.sv =====
// shared types, codes and constants of the round-robin slot scheduler
`timescale 1ns / 1ps

package rrss_pkg;

	localparam int SESSIONS         = 64;
	localparam int MAX_PACKET_BYTES = 2048;
	localparam int DESCRIPTOR_BITS  = 64;

	localparam int SLOT_W = $clog2(SESSIONS);
	localparam int LEN_W  = 16;
	localparam int DESC_W = 64;
	localparam int ENTRY_W = LEN_W + DESC_W;

	localparam logic [DESC_W-1:0] DESC_MASK = {DESC_W{1'b1}} >> (DESC_W - DESCRIPTOR_BITS);
	localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_PACKET_BYTES);
	localparam logic [7:0]        SLOT_LIMIT = 8'(SESSIONS);

	localparam logic [1:0] ACT_SUBMIT = 2'd0;
	localparam logic [1:0] ACT_TAKE   = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [2:0] ST_REJECTED = 3'd0;
	localparam logic [2:0] ST_ALREADY  = 3'd1;
	localparam logic [2:0] ST_ACCEPTED = 3'd2;
	localparam logic [2:0] ST_GRANTED  = 3'd3;
	localparam logic [2:0] ST_NONE     = 3'd4;
	localparam logic [2:0] ST_QUERY    = 3'd5;

	typedef struct packed {
		logic [1:0]        action;
		logic [7:0]        slot;
		logic [LEN_W-1:0]  msg_len;
		logic [DESC_W-1:0] request_descriptor;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] granted_slot;
		logic [LEN_W-1:0]  granted_length;
		logic [DESC_W-1:0] granted_descriptor;
		logic              is_pending;
	} rsp_t;

endpackage

// ===== sv/round_robin_slot_scheduler.sv =====
// top level of the round-robin slot scheduler
`timescale 1ns / 1ps

// Holds one pending request per session slot and hands them out in
// round-robin order.
// Command channel: a beat is taken at a rising edge with start high and
// busy low. busy is always low, so one beat can be taken every cycle.
// Result channel: done marks a result beat for exactly one cycle; the
// receiver cannot stall it, so results never back up.
// Result path: a taken command passes the command register, then the
// request ram read register, before its result shows.
// Throughput: one command per cycle; the rotated priority encode over the
// ready flags is combinational and the ram has separate read and write ports.
// Reset clears all ready flags and the rotate pointer; the request ram is
// not cleared, as an entry is only read after a submit has written it.
module round_robin_slot_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rrss_pkg::cmd_t cmd,
	output logic          done,
	output rrss_pkg::rsp_t result
);

	import rrss_pkg::*;

	logic                valid_s1;
	cmd_t                cmd_s1;
	logic                valid_s2;
	logic [2:0]          status_s2;
	logic [SLOT_W-1:0]   slot_s2;
	logic                pend_s2;
	logic [SESSIONS-1:0] flags_q;
	logic [SLOT_W-1:0]   ptr_q;

	logic [SESSIONS-1:0] flags_d;
	logic [SLOT_W-1:0]   ptr_d;
	logic [2:0]          status_d;
	logic [SLOT_W-1:0]   gslot_d;
	logic                pend_d;
	logic                we;
	logic [SLOT_W-1:0]   slot_idx;
	logic                slot_ok;
	logic [SESSIONS-1:0] upper;
	logic [SESSIONS-1:0] upper_mask;
	logic [SLOT_W-1:0]   winner;
	logic [ENTRY_W-1:0]  rdata;
	logic [ENTRY_W-1:0]  wdata;
	logic                granted;

	function automatic logic [SLOT_W-1:0] first_set(input logic [SESSIONS-1:0] v);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = SESSIONS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
			ptr_q    <= '0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				flags_q <= flags_d;
				ptr_q   <= ptr_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		status_s2 <= status_d;
		slot_s2   <= gslot_d;
		pend_s2   <= pend_d;
	end

	assign slot_idx   = cmd_s1.slot[SLOT_W-1:0];
	assign slot_ok    = cmd_s1.slot < SLOT_LIMIT;
	assign upper_mask = ~(({{(SESSIONS-1){1'b0}}, 1'b1} << ptr_q) - {{(SESSIONS-1){1'b0}}, 1'b1});
	assign upper      = flags_q & upper_mask;
	assign winner     = (|upper) ? first_set(upper) : first_set(flags_q);

	always_comb begin
		flags_d  = flags_q;
		ptr_d    = ptr_q;
		status_d = ST_REJECTED;
		gslot_d  = '0;
		pend_d   = 1'b0;
		we       = 1'b0;
		unique case (cmd_s1.action)
			ACT_SUBMIT: begin
				if (!slot_ok || cmd_s1.msg_len > MAX_LEN) begin
					status_d = ST_REJECTED;
				end else if (flags_q[slot_idx]) begin
					status_d = ST_ALREADY;
				end else begin
					status_d          = ST_ACCEPTED;
					flags_d[slot_idx] = 1'b1;
					we                = valid_s1;
				end
			end
			ACT_TAKE: begin
				if (|flags_q) begin
					status_d        = ST_GRANTED;
					gslot_d         = winner;
					flags_d[winner] = 1'b0;
					ptr_d           = winner + SLOT_W'(1);
				end else begin
					status_d = ST_NONE;
				end
			end
			ACT_QUERY: begin
				status_d = ST_QUERY;
				pend_d   = slot_ok && flags_q[slot_idx];
			end
			default: begin
				status_d = ST_REJECTED;
			end
		endcase
	end

	assign wdata = {cmd_s1.msg_len, cmd_s1.request_descriptor & DESC_MASK};

	rrss_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SESSIONS)
	) u_req_ram (
		.clk  (clk),
		.we   (we),
		.waddr(slot_idx),
		.wdata(wdata),
		.raddr(winner),
		.rdata(rdata)
	);

	assign granted = status_s2 == ST_GRANTED;

	assign done                      = valid_s2;
	assign result.status             = status_s2;
	assign result.granted_slot       = slot_s2;
	assign result.granted_length     = granted ? rdata[ENTRY_W-1:DESC_W] : '0;
	assign result.granted_descriptor = granted ? rdata[DESC_W-1:0] : '0;
	assign result.is_pending         = pend_s2;

endmodule

// ===== sv/rrss_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module rrss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/rrss_checker.sv =====
// port-level checks of the round-robin slot scheduler, bound to the top level
`timescale 1ns / 1ps

module rrss_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input rrss_pkg::cmd_t cmd,
	input logic           done,
	input rrss_pkg::rsp_t result
);

	import rrss_pkg::*;

	// one result beat per command beat
	a_beat_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(arst_n, 2) |-> done == $past(start && !busy, 2))
		else $error("result beat does not match command beat");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= ST_QUERY)
		else $error("status code out of range");

	a_grant_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_GRANTED |->
		result.granted_slot == '0 && result.granted_length == '0 &&
		result.granted_descriptor == '0)
		else $error("grant fields set on a non-grant result");

	a_pending_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_QUERY |-> !result.is_pending)
		else $error("pending flag set outside a query");

endmodule

bind round_robin_slot_scheduler rrss_checker u_rrss_checker (.*);
